// File: hdl/iib_pkg.sv
// Package for the integral image builder: register indexes, reset values,
// default geometry limits and field widths.
// No dependencies; imported by every module of the block.
package iib_pkg;

    // Default geometry limits, handed to the top level parameters
    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    // Field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned PIX_W    = 10;   // sum of up to three channels
    localparam int unsigned PIX_MAX  = 765;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned DIM_W    = 12;
    localparam int unsigned CCNT_W   = 2;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 12;
    localparam int unsigned IN_W     = 3 * CHAN_W;

    // Register indexes on the configuration port
    typedef enum logic [CFG_AW-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    // Channel selection codes
    localparam logic [CCNT_W-1:0] CH_NONE = 2'd0;
    localparam logic [CCNT_W-1:0] CH_RED  = 2'd1;
    localparam logic [CCNT_W-1:0] CH_RG   = 2'd2;
    localparam logic [CCNT_W-1:0] CH_RGB  = 2'd3;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = CH_RGB;

endpackage

// File: hdl/iib_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on iib_pkg for its parameter defaults; no other modules.
module iib_ram
    import iib_pkg::*;
#(
    parameter int unsigned WIDTH = SUM_W,
    parameter int unsigned DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/integral_image_builder_top.sv
// Integral image builder: one integral-image value per raster-ordered pixel.
// Path: the input beat and line buffer read are registered in stage 1, then the sum in the result register.
// Throughput: 1 beat per cycle while the output is not stalled by m_tready.
// Reset (rst_n low, async): frame position cleared, registers at 640/480/3.
// Line buffer contents are not cleared; the first row ignores its read data.
// Depends on iib_pkg and iib_ram.
module integral_image_builder_top
    import iib_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    // pixel stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
    // integral stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [SUM_W-1:0]  m_tdata,   // integral_sum[31:0]
    output logic              m_tlast    // frame_last
);

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned RSW = $clog2(MAX_WIDTH * PIX_MAX + 1);

    // Configuration registers
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [CCNT_W-1:0] chan_reg;
    logic              cfg_hit;

    // Frame position and row sum
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [RSW-1:0] rs_reg, rs_next;

    // Stage 1: waiting for line buffer data
    logic              s1_valid_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RSW-1:0]    s1_rs_reg;
    logic              s1_top_reg;
    logic              s1_last_reg;
    logic              s1_fwd_reg;
    logic [SUM_W-1:0]  s1_fwd_data_reg;

    // Result register
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic              out_last_reg;

    logic              accept;
    logic              s1_adv;
    logic              wr_en;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  above;
    logic [SUM_W-1:0]  sum;
    logic [PIX_W-1:0]  pix;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic              row_end;
    logic              frame_end;

    assign cfg_hit = cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT
                                || cfg_addr == REG_CHANNEL_COUNT);

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            chan_reg   <= RST_CHANNEL_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_wdata;
                REG_CHANNEL_COUNT: chan_reg   <= cfg_wdata[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    // Sum the selected channels of the incoming pixel
    always_comb
    begin
        case (chan_reg)
            CH_NONE: pix = '0;
            CH_RED:  pix = PIX_W'(s_tdata[7:0]);
            CH_RG:   pix = PIX_W'(s_tdata[7:0]) + PIX_W'(s_tdata[15:8]);
            CH_RGB:  pix = PIX_W'(s_tdata[7:0]) + PIX_W'(s_tdata[15:8])
                           + PIX_W'(s_tdata[23:16]);
            default: pix = '0;
        endcase
    end

    // Handshake: stage 1 moves when the result register is free or drains
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Advance the frame position
    assign row_end   = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign frame_end = row_end && ((HW'(row_reg) + HW'(1)) >= h_eff);

    always_comb
    begin
        rs_next  = (col_reg == '0) ? RSW'(pix) : rs_reg + RSW'(pix);
        col_next = row_end ? '0 : col_reg + CW'(1);
        if (!row_end)
            row_next = row_reg;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_reg + RW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rs_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rs_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            rs_reg  <= rs_next;
        end
    end

    // Line buffer of the previous row's integral values
    assign wr_en = s1_valid_reg && s1_adv;

    iib_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_col_reg),
        .wdata (sum),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Add the value from above to the row sum; forward a same-cycle write
    always_comb
    begin
        if (s1_top_reg)
            above = '0;
        else if (s1_fwd_reg)
            above = s1_fwd_data_reg;
        else
            above = ram_rdata;
        sum = above + SUM_W'(s1_rs_reg);
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col_reg;
            s1_rs_reg       <= rs_next;
            s1_top_reg      <= (row_reg == '0);
            s1_last_reg     <= frame_end;
            s1_fwd_reg      <= wr_en && (s1_col_reg == col_reg);
            s1_fwd_data_reg <= sum;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_sum_reg  <= sum;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/iib_checker.sv
// Port-level checks for integral_image_builder_top, bound to the top level.
// Depends on iib_pkg and integral_image_builder_top.
module iib_checker
    import iib_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [SUM_W-1:0] m_tdata,
    input logic             m_tlast
);

    // No result beat in the cycle after reset is seen
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result beat shown during reset");

    // A draining output always frees the input side
    assert property (@(posedge clk) disable iff (!rst_n) m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // An input beat taken with the output empty reaches the result register via stage 1 if the output is ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) ##1 m_tready |=> m_tvalid)
        else $error("result beat missing after two cycles");

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result beat changed");

endmodule

bind integral_image_builder_top iib_checker u_iib_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
